### rtl/bof_pkg.sv
// shared constants, types, rounding and axis-test helpers for the orthonormal frame block
package bof_pkg;

   // fixed-point format of all vector components
   localparam int FRAC_BITS = 14;
   localparam int COMP_W    = 16;
   localparam int DIM_W     = 2;

   // datapath widths
   localparam int PROD_W = 2 * COMP_W;
   localparam int DOT_W  = PROD_W + 2;
   localparam int SS_W   = PROD_W + 2;
   localparam int COEF_W = DOT_W - FRAC_BITS + 1;
   localparam int CP_W   = COEF_W + COMP_W;
   localparam int RND_W  = 48;
   localparam int VEC_W  = 24;
   localparam int MAG_W  = VEC_W;
   localparam int SQX_W  = 2 * MAG_W;
   localparam int SQ_W   = 44;
   localparam int UNIT_W = SS_W + 18;

   // square root pipeline
   localparam int ROOT_W       = SQ_W / 2;
   localparam int RREM_W       = ROOT_W + 3;
   localparam int ROOT_PER_STG = 4;
   localparam int ROOT_STG     = (ROOT_W + ROOT_PER_STG - 1) / ROOT_PER_STG;

   // divider pipeline
   localparam int QUO_W       = FRAC_BITS + 1;
   localparam int NUM_W       = MAG_W + FRAC_BITS + 1;
   localparam int DREM_W      = ROOT_W + 1;
   localparam int DIV_PER_STG = 4;
   localparam int DIV_STG     = (QUO_W + DIV_PER_STG - 1) / DIV_PER_STG;

   // dimension register codes
   localparam logic [DIM_W-1:0] DIM_2D = 2'd2;
   localparam logic [DIM_W-1:0] DIM_3D = 2'd3;
   localparam logic [DIM_W-1:0] DIM_RESET = DIM_3D;

   // one in the fixed-point format
   localparam logic signed [COMP_W-1:0] ONE = COMP_W'(1 << FRAC_BITS);

   // axis usable when 10*|h| < 9*one
   localparam int FAR_W = COMP_W + 5;
   localparam logic [FAR_W-1:0] FAR_LIM = FAR_W'(9 << FRAC_BITS);

   // lateral normal is unit when sumsq*100000 > 99999*one^2
   localparam logic [UNIT_W-1:0] UNIT_MUL = UNIT_W'(100000);
   localparam logic [UNIT_W-1:0] UNIT_LIM = UNIT_W'(64'd99999 << (2 * FRAC_BITS));

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef logic signed [VEC_W-1:0]  vec_type;

   // what travels beside the vector through the normalize and cross units
   typedef struct packed {
      logic     mode3;
      logic     active;
      logic     ok;
      comp_type h0_x;
      comp_type h0_y;
      comp_type h0_z;
      comp_type h1_x;
      comp_type h1_y;
      comp_type h1_z;
   } side_type;

   // divide by one, round to nearest, ties away from zero
   function automatic logic signed [RND_W-1:0] rnd_frac(input logic signed [RND_W-1:0] v);
      logic [RND_W-1:0] m;
      m = v[RND_W-1] ? RND_W'(-v) : RND_W'(v);
      m = (m + (RND_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      return v[RND_W-1] ? -$signed(m) : $signed(m);
   endfunction

   // component magnitude below 0.9
   function automatic logic far_axis(input comp_type v);
      logic [FAR_W-1:0] m;
      m = v[COMP_W-1] ? -FAR_W'(v) : FAR_W'(v);
      return (m * FAR_W'(10)) < FAR_LIM;
   endfunction

endpackage

### rtl/bof_if.sv
// request and response channel interfaces
interface bof_req_if import bof_pkg::*; ();
   logic     valid;
   logic     ready;
   comp_type bottom_nx;
   comp_type bottom_ny;
   comp_type bottom_nz;
   comp_type lateral_nx;
   comp_type lateral_ny;
   comp_type lateral_nz;
   logic     on_bottom;
   logic     on_lateral;

   modport source (output valid, bottom_nx, bottom_ny, bottom_nz, lateral_nx, lateral_ny,
                   lateral_nz, on_bottom, on_lateral, input ready);
   modport sink (input valid, bottom_nx, bottom_ny, bottom_nz, lateral_nx, lateral_ny,
                 lateral_nz, on_bottom, on_lateral, output ready);
endinterface

interface bof_rsp_if import bof_pkg::*; ();
   logic     valid;
   logic     ready;
   comp_type row0_x;
   comp_type row0_y;
   comp_type row0_z;
   comp_type row1_x;
   comp_type row1_y;
   comp_type row1_z;
   comp_type row2_x;
   comp_type row2_y;
   comp_type row2_z;
   logic     is_rotated;
   logic     degenerate;

   modport source (output valid, row0_x, row0_y, row0_z, row1_x, row1_y, row1_z, row2_x,
                   row2_y, row2_z, is_rotated, degenerate, input ready);
   modport sink (input valid, row0_x, row0_y, row0_z, row1_x, row1_y, row1_z, row2_x,
                 row2_y, row2_z, is_rotated, degenerate, output ready);
endinterface

### rtl/bof_setup.sv
// front stages: first row, projection coefficient and the vector to orthogonalize
module bof_setup import bof_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic [DIM_W-1:0] dim_mode,
   bof_req_if.sink          req,
   output logic             out_valid,
   output vec_type          out_x,
   output vec_type          out_y,
   output vec_type          out_z,
   output side_type         out_side
);

   typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_type;

   // stage 1 next values
   logic     mode3_in, act_in, lat_in, axok_in;
   axis_type axis_in;
   comp_type h0_in [3];
   comp_type lv_in [3];

   // stage 1 registers
   logic                     s1_valid_ff;
   logic                     s1_mode3_ff, s1_act_ff, s1_lat_ff, s1_axok_ff;
   axis_type                 s1_axis_ff;
   comp_type                 s1_h0_ff [3];
   comp_type                 s1_lv_ff [3];
   logic signed [PROD_W-1:0] s1_pd_ff [3];
   logic [PROD_W-1:0]        s1_ps_ff [3];

   // stage 2
   logic signed [DOT_W-1:0]  dot_in;
   logic signed [COEF_W-1:0] c_in;
   comp_type                 d_in [3];
   comp_type                 h0m_in;
   logic [SS_W-1:0]          ss_in;
   logic                     s2_valid_ff;
   logic                     s2_mode3_ff, s2_act_ff, s2_lat_ff, s2_axok_ff;
   comp_type                 s2_h0_ff [3];
   comp_type                 s2_d_ff [3];
   logic signed [COEF_W-1:0] s2_c_ff;
   logic [SS_W-1:0]          s2_ss_ff;

   // stage 3
   logic                   unit_in;
   logic                   s3_valid_ff;
   logic                   s3_mode3_ff, s3_act_ff, s3_ok_ff;
   comp_type               s3_h0_ff [3];
   logic signed [CP_W-1:0] s3_cp_ff [3];
   logic signed [CP_W-1:0] s3_dsh_ff [3];

   // stage 4
   logic     s4_valid_ff;
   vec_type  s4_v_ff [3];
   side_type s4_side_ff;

   assign req.ready = adv;

   // first row, axis choice
   always_comb begin
      mode3_in = (dim_mode == DIM_3D);
      act_in   = mode3_in ? (req.on_lateral | req.on_bottom)
                          : ((dim_mode == DIM_2D) & req.on_lateral);
      lat_in   = mode3_in & req.on_lateral;
      lv_in[0] = req.lateral_nx;
      lv_in[1] = req.lateral_ny;
      lv_in[2] = req.lateral_nz;
      if (mode3_in) begin
         if (req.on_lateral && !req.on_bottom) begin
            h0_in[0] = '0;
            h0_in[1] = '0;
            h0_in[2] = -ONE;
         end else begin
            h0_in[0] = req.bottom_nx;
            h0_in[1] = req.bottom_ny;
            h0_in[2] = req.bottom_nz;
         end
      end else begin
         h0_in[0] = req.lateral_nx;
         h0_in[1] = req.lateral_ny;
         h0_in[2] = '0;
      end
      axok_in = 1'b1;
      priority if (far_axis(h0_in[0])) begin
         axis_in = AX_X;
      end else if (far_axis(h0_in[1])) begin
         axis_in = AX_Y;
      end else if (mode3_in && far_axis(h0_in[2])) begin
         axis_in = AX_Z;
      end else begin
         axis_in = AX_X;
         axok_in = 1'b0;
      end
   end

   // stage 1 valid
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req.valid;
      end
   end

   // stage 1 data: dot and norm products
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_mode3_ff <= mode3_in;
         s1_act_ff   <= act_in;
         s1_lat_ff   <= lat_in;
         s1_axok_ff  <= axok_in;
         s1_axis_ff  <= axis_in;
         for (int k = 0; k < 3; k++) begin
            s1_h0_ff[k] <= h0_in[k];
            s1_lv_ff[k] <= lv_in[k];
            s1_pd_ff[k] <= PROD_W'(h0_in[k]) * PROD_W'(lv_in[k]);
            s1_ps_ff[k] <= PROD_W'(PROD_W'(lv_in[k]) * PROD_W'(lv_in[k]));
         end
      end
   end

   // coefficient and direction
   always_comb begin
      dot_in = DOT_W'(s1_pd_ff[0]) + DOT_W'(s1_pd_ff[1]) + DOT_W'(s1_pd_ff[2]);
      ss_in  = SS_W'(s1_ps_ff[0]) + SS_W'(s1_ps_ff[1]) + SS_W'(s1_ps_ff[2]);
      unique case (s1_axis_ff)
         AX_X:    h0m_in = s1_h0_ff[0];
         AX_Y:    h0m_in = s1_h0_ff[1];
         AX_Z:    h0m_in = s1_h0_ff[2];
         default: h0m_in = s1_h0_ff[0];
      endcase
      if (s1_lat_ff) begin
         c_in = COEF_W'(rnd_frac(RND_W'(dot_in)));
         for (int k = 0; k < 3; k++) begin
            d_in[k] = s1_lv_ff[k];
         end
      end else begin
         c_in    = COEF_W'(h0m_in);
         d_in[0] = (s1_axis_ff == AX_X) ? ONE : '0;
         d_in[1] = (s1_axis_ff == AX_Y) ? ONE : '0;
         d_in[2] = (s1_axis_ff == AX_Z) ? ONE : '0;
      end
   end

   // stage 2 valid
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // stage 2 data
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_mode3_ff <= s1_mode3_ff;
         s2_act_ff   <= s1_act_ff;
         s2_lat_ff   <= s1_lat_ff;
         s2_axok_ff  <= s1_axok_ff;
         s2_c_ff     <= c_in;
         s2_ss_ff    <= ss_in;
         for (int k = 0; k < 3; k++) begin
            s2_h0_ff[k] <= s1_h0_ff[k];
            s2_d_ff[k]  <= d_in[k];
         end
      end
   end

   // unit test on the lateral normal
   assign unit_in = (UNIT_W'(s2_ss_ff) * UNIT_MUL) > UNIT_LIM;

   // stage 3 valid
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // stage 3 data: projection products
   always_ff @(posedge clock) begin
      if (adv) begin
         s3_mode3_ff <= s2_mode3_ff;
         s3_act_ff   <= s2_act_ff;
         s3_ok_ff    <= s2_lat_ff ? unit_in : s2_axok_ff;
         for (int k = 0; k < 3; k++) begin
            s3_h0_ff[k]  <= s2_h0_ff[k];
            s3_cp_ff[k]  <= CP_W'(s2_c_ff) * CP_W'(s2_h0_ff[k]);
            s3_dsh_ff[k] <= CP_W'(s2_d_ff[k]) <<< FRAC_BITS;
         end
      end
   end

   // stage 4 valid
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // stage 4 data: orthogonalized vector
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            s4_v_ff[k] <= VEC_W'(rnd_frac(RND_W'(s3_dsh_ff[k]) - RND_W'(s3_cp_ff[k])));
         end
         s4_side_ff <= '{mode3: s3_mode3_ff, active: s3_act_ff, ok: s3_ok_ff,
                         h0_x: s3_h0_ff[0], h0_y: s3_h0_ff[1], h0_z: s3_h0_ff[2],
                         h1_x: '0, h1_y: '0, h1_z: '0};
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_x     = s4_v_ff[0];
   assign out_y     = s4_v_ff[1];
   assign out_z     = s4_v_ff[2];
   assign out_side  = s4_side_ff;

endmodule

### rtl/bof_norm.sv
// pipelined normalizer: sum of squares, square root, three dividers
module bof_norm import bof_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  logic     in_valid,
   input  vec_type  in_x,
   input  vec_type  in_y,
   input  vec_type  in_z,
   input  side_type in_side,
   output logic     out_valid,
   output comp_type out_x,
   output comp_type out_y,
   output comp_type out_z,
   output logic     out_nz,
   output side_type out_side
);

   vec_type v_in [3];

   // squares stage
   logic             n1_valid_ff;
   logic [MAG_W-1:0] n1_mag_ff [3];
   logic             n1_sgn_ff [3];
   logic [SQ_W-1:0]  n1_sq_ff [3];
   side_type         n1_side_ff;

   // root pipeline, entry 0 holds the sum
   logic              rt_valid_ff [ROOT_STG+1];
   logic [SQ_W-1:0]   rt_rad_ff   [ROOT_STG+1];
   logic [RREM_W-1:0] rt_rem_ff   [ROOT_STG+1];
   logic [ROOT_W-1:0] rt_root_ff  [ROOT_STG+1];
   logic [MAG_W-1:0]  rt_mag_ff   [ROOT_STG+1][3];
   logic              rt_sgn_ff   [ROOT_STG+1][3];
   side_type          rt_side_ff  [ROOT_STG+1];

   // divider pipeline, entry 0 holds the numerators
   logic              dv_valid_ff [DIV_STG+1];
   logic [NUM_W-1:0]  dv_num_ff   [DIV_STG+1][3];
   logic [DREM_W-1:0] dv_rem_ff   [DIV_STG+1][3];
   logic [QUO_W-1:0]  dv_quo_ff   [DIV_STG+1][3];
   logic              dv_sgn_ff   [DIV_STG+1][3];
   logic [ROOT_W-1:0] dv_root_ff  [DIV_STG+1];
   logic              dv_nz_ff    [DIV_STG+1];
   side_type          dv_side_ff  [DIV_STG+1];

   logic [NUM_W-1:0] num_in [3];

   assign v_in[0] = in_x;
   assign v_in[1] = in_y;
   assign v_in[2] = in_z;

   // squares
   always_ff @(posedge clock) begin
      if (reset) begin
         n1_valid_ff <= 1'b0;
      end else if (adv) begin
         n1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            n1_sgn_ff[k] <= v_in[k][VEC_W-1];
            n1_mag_ff[k] <= v_in[k][VEC_W-1] ? MAG_W'(-v_in[k]) : MAG_W'(v_in[k]);
            n1_sq_ff[k]  <= v_in[k][VEC_W-1]
                          ? SQ_W'(SQX_W'(MAG_W'(-v_in[k])) * SQX_W'(MAG_W'(-v_in[k])))
                          : SQ_W'(SQX_W'(MAG_W'(v_in[k])) * SQX_W'(MAG_W'(v_in[k])));
         end
         n1_side_ff <= in_side;
      end
   end

   // sum of squares into the root pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         rt_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         rt_valid_ff[0] <= n1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rt_rad_ff[0]  <= n1_sq_ff[0] + n1_sq_ff[1] + n1_sq_ff[2];
         rt_rem_ff[0]  <= '0;
         rt_root_ff[0] <= '0;
         rt_side_ff[0] <= n1_side_ff;
         for (int k = 0; k < 3; k++) begin
            rt_mag_ff[0][k] <= n1_mag_ff[k];
            rt_sgn_ff[0][k] <= n1_sgn_ff[k];
         end
      end
   end

   // digit-by-digit square root, a few result bits per stage
   for (genvar s = 1; s <= ROOT_STG; s++) begin : g_root
      logic [SQ_W-1:0]   rad_in;
      logic [RREM_W-1:0] rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [RREM_W-1:0] trial_in;

      always_comb begin
         rad_in   = rt_rad_ff[s-1];
         rem_in   = rt_rem_ff[s-1];
         root_in  = rt_root_ff[s-1];
         trial_in = '0;
         for (int j = 0; j < ROOT_PER_STG; j++) begin
            if ((s - 1) * ROOT_PER_STG + j < ROOT_W) begin
               rem_in   = {rem_in[RREM_W-3:0], rad_in[SQ_W-1 -: 2]};
               rad_in   = rad_in << 2;
               trial_in = RREM_W'({root_in, 2'b01});
               if (rem_in >= trial_in) begin
                  rem_in  = rem_in - trial_in;
                  root_in = {root_in[ROOT_W-2:0], 1'b1};
               end else begin
                  root_in = {root_in[ROOT_W-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rt_valid_ff[s] <= 1'b0;
         end else if (adv) begin
            rt_valid_ff[s] <= rt_valid_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rt_rad_ff[s]  <= rad_in;
            rt_rem_ff[s]  <= rem_in;
            rt_root_ff[s] <= root_in;
            rt_side_ff[s] <= rt_side_ff[s-1];
            for (int k = 0; k < 3; k++) begin
               rt_mag_ff[s][k] <= rt_mag_ff[s-1][k];
               rt_sgn_ff[s][k] <= rt_sgn_ff[s-1][k];
            end
         end
      end
   end

   // rounded numerators |v| * one + root / 2
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         num_in[k] = (NUM_W'(rt_mag_ff[ROOT_STG][k]) << FRAC_BITS)
                   + NUM_W'(rt_root_ff[ROOT_STG] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_valid_ff[0] <= rt_valid_ff[ROOT_STG];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_root_ff[0] <= rt_root_ff[ROOT_STG];
         dv_nz_ff[0]   <= (rt_root_ff[ROOT_STG] != '0);
         dv_side_ff[0] <= rt_side_ff[ROOT_STG];
         for (int k = 0; k < 3; k++) begin
            dv_num_ff[0][k] <= num_in[k];
            dv_rem_ff[0][k] <= DREM_W'(num_in[k] >> QUO_W);
            dv_quo_ff[0][k] <= '0;
            dv_sgn_ff[0][k] <= rt_sgn_ff[ROOT_STG][k];
         end
      end
   end

   // restoring division by the root, a few quotient bits per stage
   for (genvar s = 1; s <= DIV_STG; s++) begin : g_div
      logic [DREM_W-1:0] rem_in [3];
      logic [QUO_W-1:0]  quo_in [3];

      always_comb begin
         for (int k = 0; k < 3; k++) begin
            rem_in[k] = dv_rem_ff[s-1][k];
            quo_in[k] = dv_quo_ff[s-1][k];
            for (int j = 0; j < DIV_PER_STG; j++) begin
               if ((s - 1) * DIV_PER_STG + j < QUO_W) begin
                  rem_in[k] = {rem_in[k][DREM_W-2:0],
                               dv_num_ff[s-1][k][QUO_W - 1 - ((s - 1) * DIV_PER_STG + j)]};
                  if (rem_in[k] >= DREM_W'(dv_root_ff[s-1])) begin
                     rem_in[k] = rem_in[k] - DREM_W'(dv_root_ff[s-1]);
                     quo_in[k] = {quo_in[k][QUO_W-2:0], 1'b1};
                  end else begin
                     quo_in[k] = {quo_in[k][QUO_W-2:0], 1'b0};
                  end
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[s] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[s] <= dv_valid_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_root_ff[s] <= dv_root_ff[s-1];
            dv_nz_ff[s]   <= dv_nz_ff[s-1];
            dv_side_ff[s] <= dv_side_ff[s-1];
            for (int k = 0; k < 3; k++) begin
               dv_num_ff[s][k] <= dv_num_ff[s-1][k];
               dv_rem_ff[s][k] <= rem_in[k];
               dv_quo_ff[s][k] <= quo_in[k];
               dv_sgn_ff[s][k] <= dv_sgn_ff[s-1][k];
            end
         end
      end
   end

   // signed unit components
   assign out_valid = dv_valid_ff[DIV_STG];
   assign out_nz    = dv_nz_ff[DIV_STG];
   assign out_side  = dv_side_ff[DIV_STG];
   assign out_x = dv_sgn_ff[DIV_STG][0] ? -COMP_W'(dv_quo_ff[DIV_STG][0])
                                        : COMP_W'(dv_quo_ff[DIV_STG][0]);
   assign out_y = dv_sgn_ff[DIV_STG][1] ? -COMP_W'(dv_quo_ff[DIV_STG][1])
                                        : COMP_W'(dv_quo_ff[DIV_STG][1]);
   assign out_z = dv_sgn_ff[DIV_STG][2] ? -COMP_W'(dv_quo_ff[DIV_STG][2])
                                        : COMP_W'(dv_quo_ff[DIV_STG][2]);

endmodule

### rtl/bof_cross.sv
// cross product of the first two rows, two stages
module bof_cross import bof_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  logic     in_valid,
   input  comp_type in_h1_x,
   input  comp_type in_h1_y,
   input  comp_type in_h1_z,
   input  logic     in_nz,
   input  side_type in_side,
   output logic     out_valid,
   output vec_type  out_x,
   output vec_type  out_y,
   output vec_type  out_z,
   output side_type out_side
);

   side_type                 side_in;
   logic                     c1_valid_ff;
   logic signed [PROD_W-1:0] c1_p_ff [6];
   side_type                 c1_side_ff;
   logic                     c2_valid_ff;
   vec_type                  c2_x_ff [3];
   side_type                 c2_side_ff;

   // second row joins the side data
   always_comb begin
      side_in      = in_side;
      side_in.h1_x = in_h1_x;
      side_in.h1_y = in_h1_y;
      side_in.h1_z = in_h1_z;
      side_in.ok   = in_side.ok & in_nz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
         c2_valid_ff <= 1'b0;
      end else if (adv) begin
         c1_valid_ff <= in_valid;
         c2_valid_ff <= c1_valid_ff;
      end
   end

   // partial products
   always_ff @(posedge clock) begin
      if (adv) begin
         c1_p_ff[0] <= PROD_W'(in_side.h0_y) * PROD_W'(in_h1_z);
         c1_p_ff[1] <= PROD_W'(in_h1_y) * PROD_W'(in_side.h0_z);
         c1_p_ff[2] <= PROD_W'(in_h1_x) * PROD_W'(in_side.h0_z);
         c1_p_ff[3] <= PROD_W'(in_side.h0_x) * PROD_W'(in_h1_z);
         c1_p_ff[4] <= PROD_W'(in_side.h0_x) * PROD_W'(in_h1_y);
         c1_p_ff[5] <= PROD_W'(in_h1_x) * PROD_W'(in_side.h0_y);
         c1_side_ff <= side_in;
      end
   end

   // differences rounded back to the component format
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            c2_x_ff[k] <= VEC_W'(rnd_frac(RND_W'(c1_p_ff[2*k]) - RND_W'(c1_p_ff[2*k+1])));
         end
         c2_side_ff <= c1_side_ff;
      end
   end

   assign out_valid = c2_valid_ff;
   assign out_x     = c2_x_ff[0];
   assign out_y     = c2_x_ff[1];
   assign out_z     = c2_x_ff[2];
   assign out_side  = c2_side_ff;

endmodule

### rtl/boundary_orthonormal_frame.sv
// orthonormal rotation frame for one boundary node, fully pipelined
//
//   channel   direction  handshake         payload
//   req_chan  in         valid / ready     bottom and lateral normals, boundary flags
//   rsp_chan  out        valid / ready     nine frame components, is_rotated, degenerate
//   csr       in         csr_wr_en         dim_mode (2 bits)
//
// one node per cycle while no rsp beat is stalled; 33 register stages
// the stages are the two normalizers (22-bit square root, 4 bits per stage,
// then 15-bit quotients, 4 bits per stage) plus setup, cross and output stages
// a stalled rsp beat holds the whole pipeline; nothing is dropped or repeated
// synchronous active-high reset clears all valid bits and sets dim_mode to 3
module boundary_orthonormal_frame import bof_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   bof_req_if.sink          req_chan,
   bof_rsp_if.source        rsp_chan,
   input  logic             csr_wr_en,
   input  logic [DIM_W-1:0] csr_wr_data
);

   logic [DIM_W-1:0] dim_ff;
   logic             adv;

   logic     su_valid;
   vec_type  su_x, su_y, su_z;
   side_type su_side;
   logic     n1_valid, n1_nz;
   comp_type n1_x, n1_y, n1_z;
   side_type n1_side;
   logic     cr_valid;
   vec_type  cr_x, cr_y, cr_z;
   side_type cr_side;
   logic     n2_valid, n2_nz;
   comp_type n2_x, n2_y, n2_z;
   side_type n2_side;

   logic     fin_ok, rot_in, deg_in;
   comp_type row_in [9];
   logic     out_valid_ff, rot_ff, deg_ff;
   comp_type row_ff [9];

   // dimension register
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= DIM_RESET;
      end else if (csr_wr_en) begin
         dim_ff <= csr_wr_data;
      end
   end

   // pipeline moves when the output beat is empty or being taken
   assign adv = !out_valid_ff || rsp_chan.ready;

   bof_setup u_setup (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .dim_mode (dim_ff),
      .req      (req_chan),
      .out_valid(su_valid),
      .out_x    (su_x),
      .out_y    (su_y),
      .out_z    (su_z),
      .out_side (su_side)
   );

   bof_norm u_norm_row1 (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (su_valid),
      .in_x     (su_x),
      .in_y     (su_y),
      .in_z     (su_z),
      .in_side  (su_side),
      .out_valid(n1_valid),
      .out_x    (n1_x),
      .out_y    (n1_y),
      .out_z    (n1_z),
      .out_nz   (n1_nz),
      .out_side (n1_side)
   );

   bof_cross u_cross (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (n1_valid),
      .in_h1_x  (n1_x),
      .in_h1_y  (n1_y),
      .in_h1_z  (n1_z),
      .in_nz    (n1_nz),
      .in_side  (n1_side),
      .out_valid(cr_valid),
      .out_x    (cr_x),
      .out_y    (cr_y),
      .out_z    (cr_z),
      .out_side (cr_side)
   );

   bof_norm u_norm_row2 (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (cr_valid),
      .in_x     (cr_x),
      .in_y     (cr_y),
      .in_z     (cr_z),
      .in_side  (cr_side),
      .out_valid(n2_valid),
      .out_x    (n2_x),
      .out_y    (n2_y),
      .out_z    (n2_z),
      .out_nz   (n2_nz),
      .out_side (n2_side)
   );

   // assemble the frame; the cross product only counts in 3d
   always_comb begin
      fin_ok = n2_side.ok & (!n2_side.mode3 | n2_nz);
      rot_in = 1'b0;
      deg_in = 1'b0;
      for (int k = 0; k < 9; k++) begin
         row_in[k] = '0;
      end
      if (n2_side.active) begin
         if (fin_ok) begin
            rot_in = 1'b1;
            if (n2_side.mode3) begin
               row_in[0] = n2_side.h0_x;
               row_in[1] = n2_side.h0_y;
               row_in[2] = n2_side.h0_z;
               row_in[3] = n2_side.h1_x;
               row_in[4] = n2_side.h1_y;
               row_in[5] = n2_side.h1_z;
               row_in[6] = n2_x;
               row_in[7] = n2_y;
               row_in[8] = n2_z;
            end else begin
               row_in[0] = n2_side.h0_x;
               row_in[1] = n2_side.h0_y;
               row_in[2] = n2_side.h1_x;
               row_in[3] = n2_side.h1_y;
            end
         end else begin
            deg_in = 1'b1;
         end
      end
   end

   // output beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= n2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rot_ff <= rot_in;
         deg_ff <= deg_in;
         for (int k = 0; k < 9; k++) begin
            row_ff[k] <= row_in[k];
         end
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.row0_x     = row_ff[0];
   assign rsp_chan.row0_y     = row_ff[1];
   assign rsp_chan.row0_z     = row_ff[2];
   assign rsp_chan.row1_x     = row_ff[3];
   assign rsp_chan.row1_y     = row_ff[4];
   assign rsp_chan.row1_z     = row_ff[5];
   assign rsp_chan.row2_x     = row_ff[6];
   assign rsp_chan.row2_y     = row_ff[7];
   assign rsp_chan.row2_z     = row_ff[8];
   assign rsp_chan.is_rotated = rot_ff;
   assign rsp_chan.degenerate = deg_ff;

endmodule

### rtl/bof_checker.sv
// port-level checks for the orthonormal frame block, bound to the top level
module bof_checker import bof_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input comp_type row0_x,
   input comp_type row0_y,
   input comp_type row0_z,
   input comp_type row1_x,
   input comp_type row1_y,
   input comp_type row1_z,
   input comp_type row2_x,
   input comp_type row2_y,
   input comp_type row2_z,
   input logic     is_rotated,
   input logic     degenerate
);

   // a beat is never both rotated and degenerate
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(is_rotated && degenerate))
      else $error("rotated and degenerate both set");

   // an unrotated beat carries a zero matrix
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !is_rotated) |->
         (row0_x == 0 && row0_y == 0 && row0_z == 0 && row1_x == 0 && row1_y == 0 &&
          row1_z == 0 && row2_x == 0 && row2_y == 0 && row2_z == 0))
      else $error("unrotated beat with nonzero matrix");

   // the input side only stalls behind a waiting output beat
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled with output free");

   // a stalled output beat holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(row0_x) && $stable(is_rotated)))
      else $error("stalled output beat changed");

endmodule

bind boundary_orthonormal_frame bof_checker u_bof_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .row0_x    (rsp_chan.row0_x),
   .row0_y    (rsp_chan.row0_y),
   .row0_z    (rsp_chan.row0_z),
   .row1_x    (rsp_chan.row1_x),
   .row1_y    (rsp_chan.row1_y),
   .row1_z    (rsp_chan.row1_z),
   .row2_x    (rsp_chan.row2_x),
   .row2_y    (rsp_chan.row2_y),
   .row2_z    (rsp_chan.row2_z),
   .is_rotated(rsp_chan.is_rotated),
   .degenerate(rsp_chan.degenerate)
);

### test/boundary_orthonormal_frame_checker.sv
// frame checker: watches both channels, predicts each frame and compares field by field
`timescale 1ns / 1ps
module boundary_orthonormal_frame_checker import bof_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   bof_req_if               req_chan,
   bof_rsp_if               rsp_chan,
   input  logic             csr_wr_en,
   input  logic [DIM_W-1:0] csr_wr_data,
   output int               fail_count,
   output int               pending_frames
);

   typedef struct packed {
      comp_type row0_x;
      comp_type row0_y;
      comp_type row0_z;
      comp_type row1_x;
      comp_type row1_y;
      comp_type row1_z;
      comp_type row2_x;
      comp_type row2_y;
      comp_type row2_z;
      logic     is_rotated;
      logic     degenerate;
   } frame_type;

   frame_type        frame_queue[$];
   logic [DIM_W-1:0] dim_shadow;

   function automatic longint clamp16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint fix_round(input longint v);
      longint m;
      m = v < 0 ? -v : v;
      m = (m + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return v < 0 ? -m : m;
   endfunction

   function automatic longint int_sqrt(input longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   // unit vector of n components; false when the norm is zero
   function automatic bit unit_vec(input longint v[3], input int n, output longint o[3]);
      longint unsigned s, r, q, m;
      s = 0;
      o = '{0, 0, 0};
      for (int k = 0; k < n; k++) begin
         m = v[k] < 0 ? -v[k] : v[k];
         s += m * m;
      end
      r = int_sqrt(s);
      if (r == 0) return 0;
      for (int k = 0; k < n; k++) begin
         m = v[k] < 0 ? -v[k] : v[k];
         q = ((m << FRAC_BITS) + r / 2) / r;
         o[k] = clamp16(v[k] < 0 ? -longint'(q) : longint'(q));
      end
      return 1;
   endfunction

   // remove the h0 component from d, then normalize
   function automatic bit orthogonalize(input longint h0[3], input longint d[3],
                                        input longint c, input int n, output longint o[3]);
      longint v[3];
      v = '{0, 0, 0};
      for (int k = 0; k < n; k++) v[k] = fix_round(d[k] * (64'sd1 <<< FRAC_BITS) - c * h0[k]);
      return unit_vec(v, n, o);
   endfunction

   function automatic int first_far_axis(input longint h0[3], input int n);
      for (int m = 0; m < n; m++) begin
         if ((h0[m] < 0 ? -h0[m] : h0[m]) * 10 < (64'sd9 <<< FRAC_BITS)) return m;
      end
      return -1;
   endfunction

   function automatic frame_type predict_frame(input logic [DIM_W-1:0] dim,
         input longint b[3], input longint lat[3], input bit bot, input bit lt);
      longint one, h0[3], h1[3], h2[3], d[3], x[3], rows[9], c, dot;
      longint unsigned ss;
      bit ok, rot, deg;
      int m;
      frame_type f;
      one = 64'sd1 <<< FRAC_BITS;
      rows = '{default: 0};
      h0 = '{0, 0, 0};
      h1 = '{0, 0, 0};
      rot = 0;
      deg = 0;
      if (dim == DIM_3D && (lt || bot)) begin
         ok = 1;
         if (lt) begin
            ss = 0;
            dot = 0;
            for (int k = 0; k < 3; k++) begin
               h0[k] = bot ? b[k] : 0;
               ss += lat[k] * lat[k];
            end
            if (!bot) h0[2] = clamp16(-one);
            if (FRAC_BITS > 20 || ss * 100000 <= (64'd99999 << (2 * FRAC_BITS))) ok = 0;
            for (int k = 0; k < 3; k++) dot += h0[k] * lat[k];
            c = fix_round(dot);
            if (ok) ok = orthogonalize(h0, lat, c, 3, h1);
         end else begin
            h0 = b;
            m = first_far_axis(h0, 3);
            if (m < 0) ok = 0;
            else begin
               for (int k = 0; k < 3; k++) d[k] = (k == m) ? one : 0;
               ok = orthogonalize(h0, d, h0[m], 3, h1);
            end
         end
         if (ok) begin
            x[0] = fix_round(h0[1] * h1[2] - h1[1] * h0[2]);
            x[1] = fix_round(h1[0] * h0[2] - h0[0] * h1[2]);
            x[2] = fix_round(h0[0] * h1[1] - h1[0] * h0[1]);
            ok = unit_vec(x, 3, h2);
         end
         if (ok) begin
            for (int k = 0; k < 3; k++) begin
               rows[k] = clamp16(h0[k]);
               rows[3 + k] = h1[k];
               rows[6 + k] = h2[k];
            end
            rot = 1;
         end else deg = 1;
      end else if (dim == DIM_2D && lt) begin
         h0 = '{lat[0], lat[1], 0};
         m = first_far_axis(h0, 2);
         if (m >= 0) begin
            d = '{(m == 0) ? one : 0, (m == 1) ? one : 0, 0};
            if (orthogonalize(h0, d, h0[m], 2, h1)) begin
               rows[0] = h0[0];
               rows[1] = h0[1];
               rows[2] = h1[0];
               rows[3] = h1[1];
               rot = 1;
            end else deg = 1;
         end else deg = 1;
      end
      f.row0_x = rows[0][15:0];
      f.row0_y = rows[1][15:0];
      f.row0_z = rows[2][15:0];
      f.row1_x = rows[3][15:0];
      f.row1_y = rows[4][15:0];
      f.row1_z = rows[5][15:0];
      f.row2_x = rows[6][15:0];
      f.row2_y = rows[7][15:0];
      f.row2_z = rows[8][15:0];
      f.is_rotated = rot;
      f.degenerate = deg;
      return f;
   endfunction

   assign pending_frames = frame_queue.size();

   // track the dimension register and predict each accepted request beat
   always @(posedge clock) begin
      longint b[3], lat[3];
      if (reset) begin
         dim_shadow <= DIM_RESET;
      end else begin
         if (csr_wr_en) dim_shadow <= csr_wr_data;
         if (req_chan.valid && req_chan.ready) begin
            b = '{req_chan.bottom_nx, req_chan.bottom_ny, req_chan.bottom_nz};
            lat = '{req_chan.lateral_nx, req_chan.lateral_ny, req_chan.lateral_nz};
            frame_queue.push_back(predict_frame(dim_shadow, b, lat,
               req_chan.on_bottom, req_chan.on_lateral));
         end
      end
   end

   // compare each response beat with the oldest prediction
   initial fail_count = 0;
   always @(posedge clock) begin
      frame_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.row0_x, rsp_chan.row0_y, rsp_chan.row0_z, rsp_chan.row1_x,
                 rsp_chan.row1_y, rsp_chan.row1_z, rsp_chan.row2_x, rsp_chan.row2_y,
                 rsp_chan.row2_z, rsp_chan.is_rotated, rsp_chan.degenerate};
         if (frame_queue.size() == 0) begin
            if (fail_count < 10) $display("unexpected rsp beat: %p", got);
            fail_count++;
         end else begin
            want = frame_queue.pop_front();
            if (got !== want) begin
               if (fail_count < 10) $display("mismatch: expected %p actual %p", want, got);
               fail_count++;
            end
         end
      end
   end

endmodule

### test/boundary_orthonormal_frame_tb.sv
// testbench top: clock, reset, stimulus, receiver stalls and the verdict
`timescale 1ns / 1ps
module boundary_orthonormal_frame_tb;
   import bof_pkg::*;

   localparam int LATENCY   = 33;
   localparam int LIMIT     = 400000;
   localparam int RANDOM_N  = 1630;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [DIM_W-1:0] csr_wr_data;
   int               fail_count;
   int               pending_frames;
   int               cycle_count;
   bit               long_hold;

   bof_req_if req_chan ();
   bof_rsp_if rsp_chan ();

   boundary_orthonormal_frame uut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   boundary_orthonormal_frame_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_frames(pending_frames)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver: random stalls per beat, plus one long hold-off
   initial begin
      rsp_chan.ready = 1'b0;
      long_hold = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_chan.ready <= 1'b0;
            repeat (200) @(posedge clock);
            long_hold = 1'b0;
         end
         if ($urandom_range(3) == 0) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(11)) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         rsp_chan.ready <= 1'b0;
         if ($urandom_range(5) == 0) rsp_chan.ready <= 1'b1;
      end
   end

   task automatic send_node(input comp_type bx, by, bz, lx, ly, lz, input logic bot, lat,
                            input bit no_gap);
      if (!no_gap) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(11)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.bottom_nx  <= bx;
      req_chan.bottom_ny  <= by;
      req_chan.bottom_nz  <= bz;
      req_chan.lateral_nx <= lx;
      req_chan.lateral_ny <= ly;
      req_chan.lateral_nz <= lz;
      req_chan.on_bottom  <= bot;
      req_chan.on_lateral <= lat;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   function automatic comp_type rand_unit_comp();
      return comp_type'($signed($urandom_range(2 * ONE)) - ONE);
   endfunction

   // random node: mostly near-unit normals with random flags, some raw noise
   task automatic send_random(input bit no_gap);
      comp_type v[6];
      int s;
      s = $urandom_range(9);
      for (int k = 0; k < 6; k++) v[k] = (s == 0) ? comp_type'($urandom) : rand_unit_comp();
      if (s >= 2 && s < 8) begin
         // unit lateral normal, axis-aligned or (3/5, 4/5, 0), so the unit test passes
         v[3] = 0; v[4] = 0; v[5] = 0;
         v[3 + $urandom_range(2)] = $urandom_range(1) ? ONE : -ONE;
         if (s >= 5) begin
            v[3] = comp_type'(($signed(ONE) * 3) / 5);
            v[4] = comp_type'(($signed(ONE) * 4) / 5) + 1;
            v[5] = 0;
         end
      end
      send_node(v[0], v[1], v[2], v[3], v[4], v[5], 1'($urandom_range(1)),
                1'($urandom_range(1)), no_gap);
   endtask

   task automatic drain_and_write(input logic [DIM_W-1:0] value);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_frames != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // stimulus
   initial begin
      logic [DIM_W-1:0] modes[6];
      modes = '{DIM_3D, DIM_2D, 2'd0, DIM_3D, 2'd1, DIM_2D};
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_chan.valid = 1'b0;
      req_chan.bottom_nx = 0; req_chan.bottom_ny = 0; req_chan.bottom_nz = 0;
      req_chan.lateral_nx = 0; req_chan.lateral_ny = 0; req_chan.lateral_nz = 0;
      req_chan.on_bottom = 0; req_chan.on_lateral = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed nodes in the reset 3D mode
      send_node(0, 0, -ONE, ONE, 0, 0, 1, 1, 0);             // bottom and lateral
      send_node(0, 0, 0, 0, ONE, 0, 0, 1, 0);                // lateral only, straight down
      send_node(0, 0, ONE, 0, 0, 0, 1, 0, 0);                // bottom only, x axis
      send_node(ONE, 0, 0, 0, 0, 0, 1, 0, 0);                // bottom only, y axis
      send_node(ONE, ONE, ONE, 0, 0, 0, 1, 0, 0);            // no usable axis
      send_node(0, 0, 0, 0, 0, 0, 1, 0, 0);                  // zero bottom normal
      send_node(0, 0, 0, 100, 0, 0, 0, 1, 0);                // lateral not unit
      send_node(0, 0, ONE, 0, 0, ONE, 1, 1, 0);              // parallel: zero norm
      send_node(0, 0, 0, 0, 0, 0, 0, 0, 0);                  // not constrained
      send_node(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1, 1, 0);
      send_node(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1, 1, 0);
      send_node(16'sh8000, 0, 0, 0, 16'sh7fff, 0, 1, 1, 0);
      drain_and_write(DIM_2D);
      send_node(0, 0, 0, ONE, 0, 0, 0, 1, 0);                // 2D, y axis
      send_node(0, 0, 0, 0, ONE, 0, 0, 1, 0);                // 2D, x axis
      send_node(0, 0, 0, ONE, ONE, 0, 0, 1, 0);              // 2D, no usable axis
      send_node(0, 0, 0, 0, 0, 0, 0, 1, 0);                  // 2D, zero lateral normal
      send_node(ONE, 0, 0, 0, 0, 0, 1, 0, 0);                // 2D, not lateral
      send_node(0, 0, 0, 16'sh8000, 16'sh7fff, 16'sh8000, 1, 1, 0);

      // random phases through every register value
      foreach (modes[p]) begin
         drain_and_write(modes[p]);
         for (int i = 0; i < RANDOM_N / 6; i++) begin
            if (p == 3 && i == 20) long_hold = 1'b1;
            send_random((p == 3) || ($urandom_range(4) == 0));
         end
      end
      req_chan.valid <= 1'b0;

      @(posedge clock);
      while (pending_frames != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (fail_count == 0 && pending_frames == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
